// ===== hdl/gss_pkg.sv =====
package gss_pkg;

    localparam int OP_W     = 4;
    localparam int MIN_W    = 10;
    localparam int LIMIT_W  = 5;
    localparam int BATT_W   = 8;
    localparam int NOTICE_W = 3;
    localparam int TO_W     = 17;
    localparam int HO_W     = 11;
    localparam int CFG_IDX_W = 2;

    localparam int TICKS_PER_SECOND_DEF = 2;

    localparam logic [OP_W-1:0] OP_TICK       = 4'd0;
    localparam logic [OP_W-1:0] OP_MANUAL_ON  = 4'd1;
    localparam logic [OP_W-1:0] OP_MANUAL_OFF = 4'd2;
    localparam logic [OP_W-1:0] OP_REMOTE_ON  = 4'd3;
    localparam logic [OP_W-1:0] OP_REMOTE_OFF = 4'd4;
    localparam logic [OP_W-1:0] OP_BUS_ON     = 4'd5;
    localparam logic [OP_W-1:0] OP_BUS_OFF    = 4'd6;
    localparam logic [OP_W-1:0] OP_SCHED_ON   = 4'd7;
    localparam logic [OP_W-1:0] OP_SCHED_OFF  = 4'd8;

    localparam logic [NOTICE_W-1:0] NOTICE_NONE     = 3'd0;
    localparam logic [NOTICE_W-1:0] NOTICE_IGNORED  = 3'd1;
    localparam logic [NOTICE_W-1:0] NOTICE_STARTED  = 3'd2;
    localparam logic [NOTICE_W-1:0] NOTICE_AT_LIMIT = 3'd3;
    localparam logic [NOTICE_W-1:0] NOTICE_STOPPED  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_REMOTE_RUN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWBATT_RUN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TEST_RUN    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BATT_LIMIT  = 2'd3;

    localparam logic [MIN_W-1:0]   RUN_MINUTES_MAX   = 10'd600;
    localparam logic [MIN_W-1:0]   REMOTE_RUN_RESET  = 10'd10;
    localparam logic [LIMIT_W-1:0] BATT_LIMIT_RESET  = 5'd10;
    localparam logic [LIMIT_W-1:0] BATT_LIMIT_MIN    = 5'd10;
    localparam logic [LIMIT_W-1:0] BATT_LIMIT_MAX    = 5'd30;
    localparam logic [TO_W-1:0]    TIMEOUT_MAX       = 17'd131071;
    localparam logic [HO_W-1:0]    HOLDOFF_MAX       = 11'd2047;

    localparam int RUN_LOSS_TICKS = 10;

endpackage

// ===== hdl/generator_start_supervisor.sv =====
// channel   direction  handshake            payload
// s_        in         s_valid / s_ready    opcode, manual_mode, run_sense, battery_level
// m_        out        m_valid / m_ready    start_relay, out_positive, out_negative,
//                                           is_running, fail_alarm, notice
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// one transaction per cycle sustained while m_ready stays high; s_ to m_ passes
// through the input register, then the state update into the result register
// reset is synchronous on aresetn; state and configuration go to defaults
// a stalled m_ side holds the result; s_ takes one more transaction into the
// input register while the result waits, then stalls until m_ready
module generator_start_supervisor #(
    parameter int TICKS_PER_SECOND = gss_pkg::TICKS_PER_SECOND_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [gss_pkg::OP_W-1:0]       s_opcode,
    input  logic                           s_manual_mode,
    input  logic                           s_run_sense,
    input  logic [gss_pkg::BATT_W-1:0]     s_battery_level,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_start_relay,
    output logic                           m_out_positive,
    output logic                           m_out_negative,
    output logic                           m_is_running,
    output logic                           m_fail_alarm,
    output logic [gss_pkg::NOTICE_W-1:0]   m_notice,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gss_pkg::MIN_W-1:0]      cfg_data
);
    import gss_pkg::*;

    localparam int T10 = 10 * TICKS_PER_SECOND;
    localparam int T20 = 20 * TICKS_PER_SECOND;
    localparam int T30 = 30 * TICKS_PER_SECOND;
    localparam int PC_W = $clog2(T30 + 1);
    localparam int TPM = 60 * TICKS_PER_SECOND;
    localparam int TO_RAW_W = MIN_W + $clog2(TPM + 1);
    localparam int TO_PROD_W = (TO_RAW_W > TO_W) ? TO_RAW_W : TO_W;
    localparam int HO_RAW_W = MIN_W + $clog2(TICKS_PER_SECOND + 1);
    localparam int HO_PROD_W = (HO_RAW_W > HO_W) ? HO_RAW_W : HO_W;

    // configuration
    logic [MIN_W-1:0]   remote_min_reg;
    logic [MIN_W-1:0]   lowbatt_min_reg;
    logic [MIN_W-1:0]   test_min_reg;
    logic [LIMIT_W-1:0] batt_limit_reg;

    // input register
    logic               in_valid_reg;
    logic [OP_W-1:0]    in_op_reg;
    logic               in_manual_reg;
    logic               in_sense_reg;
    logic [BATT_W-1:0]  in_batt_reg;

    // supervisor state
    logic               contact_reg, contact_next;
    logic               running_reg, running_next;
    logic               alarm_reg, alarm_next;
    logic               pos_reg, pos_next;
    logic               neg_reg, neg_next;
    logic [PC_W-1:0]    phase_reg, phase_next;
    logic [TO_W-1:0]    tleft_reg, tleft_next;
    logic               armed_reg, armed_next;
    logic               is_test_reg, is_test_next;
    logic [HO_W-1:0]    holdoff_reg, holdoff_next;
    logic [NOTICE_W-1:0] notice_next;

    // result register
    logic               out_valid_reg;
    logic               res_relay_reg;
    logic               res_pos_reg;
    logic               res_neg_reg;
    logic               res_running_reg;
    logic               res_alarm_reg;
    logic [NOTICE_W-1:0] res_notice_reg;

    logic advance;
    logic do_step;

    logic [MIN_W-1:0]     remote_clamp, test_clamp, lowbatt_clamp;
    logic [TO_PROD_W-1:0] remote_prod, test_prod, lowbatt_prod;
    logic [TO_W-1:0]      remote_ticks, test_ticks, lowbatt_ticks;
    logic [HO_PROD_W-1:0] holdoff_prod;
    logic [HO_W-1:0]      holdoff_load;
    logic [LIMIT_W-1:0]   batt_lim;

    assign advance   = !out_valid_reg || m_ready;
    assign do_step   = in_valid_reg && advance;
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_comb begin
        remote_clamp  = (remote_min_reg > RUN_MINUTES_MAX) ? RUN_MINUTES_MAX : remote_min_reg;
        test_clamp    = (test_min_reg > RUN_MINUTES_MAX) ? RUN_MINUTES_MAX : test_min_reg;
        lowbatt_clamp = (lowbatt_min_reg > RUN_MINUTES_MAX) ? RUN_MINUTES_MAX : lowbatt_min_reg;
        remote_prod   = TO_PROD_W'(remote_clamp) * TO_PROD_W'(TPM);
        test_prod     = TO_PROD_W'(test_clamp) * TO_PROD_W'(TPM);
        lowbatt_prod  = TO_PROD_W'(lowbatt_clamp) * TO_PROD_W'(TPM);
        remote_ticks  = (remote_prod > TO_PROD_W'(TIMEOUT_MAX)) ? TIMEOUT_MAX
                                                                : remote_prod[TO_W-1:0];
        test_ticks    = (test_prod > TO_PROD_W'(TIMEOUT_MAX)) ? TIMEOUT_MAX
                                                              : test_prod[TO_W-1:0];
        lowbatt_ticks = (lowbatt_prod > TO_PROD_W'(TIMEOUT_MAX)) ? TIMEOUT_MAX
                                                                 : lowbatt_prod[TO_W-1:0];
        holdoff_prod  = HO_PROD_W'(lowbatt_min_reg) * HO_PROD_W'(TICKS_PER_SECOND);
        holdoff_load  = (holdoff_prod > HO_PROD_W'(HOLDOFF_MAX)) ? HOLDOFF_MAX
                                                                 : holdoff_prod[HO_W-1:0];
        if (batt_limit_reg < BATT_LIMIT_MIN) begin
            batt_lim = BATT_LIMIT_MIN;
        end else if (batt_limit_reg > BATT_LIMIT_MAX) begin
            batt_lim = BATT_LIMIT_MAX;
        end else begin
            batt_lim = batt_limit_reg;
        end
    end

    always_comb begin
        logic            tick;
        logic [OP_W-1:0] ev;
        logic            fail;

        contact_next = contact_reg;
        running_next = running_reg;
        alarm_next   = alarm_reg;
        pos_next     = pos_reg;
        neg_next     = neg_reg;
        phase_next   = phase_reg;
        tleft_next   = tleft_reg;
        armed_next   = armed_reg;
        is_test_next = is_test_reg;
        holdoff_next = holdoff_reg;
        notice_next  = NOTICE_NONE;
        fail         = 1'b0;

        tick = (in_op_reg == OP_TICK);
        ev   = in_op_reg;

        // run timeout countdown, expiry turns into an off command
        if (tick && armed_reg) begin
            if (tleft_reg != '0) begin
                tleft_next = tleft_reg - 1'b1;
            end
            if (tleft_next == '0) begin
                armed_next = 1'b0;
                ev = is_test_reg ? OP_SCHED_OFF : OP_REMOTE_OFF;
            end
        end

        case (ev)
            OP_MANUAL_ON: begin
                contact_next = 1'b1;
            end
            OP_MANUAL_OFF: begin
                contact_next = 1'b0;
                alarm_next   = 1'b0;
            end
            OP_REMOTE_ON: begin
                if (in_manual_reg) begin
                    notice_next = NOTICE_IGNORED;
                end else begin
                    if (!contact_reg) begin
                        tleft_next   = remote_ticks;
                        armed_next   = 1'b1;
                        is_test_next = 1'b0;
                        contact_next = 1'b1;
                        alarm_next   = 1'b0;
                    end
                    notice_next = (remote_min_reg >= RUN_MINUTES_MAX) ? NOTICE_AT_LIMIT
                                                                      : NOTICE_STARTED;
                end
            end
            OP_REMOTE_OFF: begin
                if (in_manual_reg) begin
                    notice_next = NOTICE_IGNORED;
                end else begin
                    contact_next = 1'b0;
                    notice_next  = NOTICE_STOPPED;
                end
            end
            OP_BUS_ON: begin
                if (!in_manual_reg && !contact_reg) begin
                    tleft_next   = remote_ticks;
                    armed_next   = 1'b1;
                    is_test_next = 1'b0;
                    contact_next = 1'b1;
                    alarm_next   = 1'b0;
                end
            end
            OP_BUS_OFF: begin
                if (!in_manual_reg) begin
                    contact_next = 1'b0;
                end
            end
            OP_SCHED_ON: begin
                if (!in_manual_reg && !contact_reg) begin
                    contact_next = 1'b1;
                    tleft_next   = test_ticks;
                    armed_next   = 1'b1;
                    is_test_next = 1'b1;
                end
            end
            OP_SCHED_OFF: begin
                contact_next = 1'b0;
            end
            default: begin
            end
        endcase

        if (tick) begin
            // start sequence and run watch
            if (contact_next) begin
                if (!running_reg) begin
                    if (phase_reg == PC_W'(T10)) begin
                        neg_next   = 1'b1;
                        pos_next   = 1'b0;
                        phase_next = phase_reg + 1'b1;
                    end else if (phase_reg == PC_W'(T30)) begin
                        fail = 1'b1;
                    end else if (phase_reg > PC_W'(T20)) begin
                        if (in_sense_reg) begin
                            running_next = 1'b1;
                            phase_next   = '0;
                            alarm_next   = 1'b0;
                            pos_next     = 1'b1;
                            neg_next     = 1'b1;
                        end else begin
                            phase_next = phase_reg + 1'b1;
                        end
                    end else begin
                        phase_next = phase_reg + 1'b1;
                    end
                end else begin
                    if (in_sense_reg) begin
                        phase_next = '0;
                    end else begin
                        phase_next = phase_reg + 1'b1;
                        if (phase_next == PC_W'(RUN_LOSS_TICKS)) begin
                            fail = 1'b1;
                        end
                    end
                end
                if (fail) begin
                    alarm_next   = 1'b1;
                    running_next = 1'b0;
                    contact_next = 1'b0;
                    pos_next     = 1'b0;
                    neg_next     = 1'b0;
                    phase_next   = '0;
                    armed_next   = 1'b0;
                end
            end else begin
                running_next = 1'b0;
                phase_next   = '0;
            end

            // low battery automatic start
            if (lowbatt_min_reg != '0 && !contact_next) begin
                if (in_batt_reg < BATT_W'(batt_lim) && in_batt_reg != '0 &&
                    holdoff_reg == '0) begin
                    holdoff_next = holdoff_load;
                    if (!in_manual_reg && !alarm_next) begin
                        contact_next = 1'b1;
                        tleft_next   = lowbatt_ticks;
                        armed_next   = 1'b1;
                        is_test_next = 1'b0;
                    end
                end else if (holdoff_reg != '0) begin
                    holdoff_next = holdoff_reg - 1'b1;
                end
            end
        end

        if (!contact_next) begin
            running_next = 1'b0;
            phase_next   = '0;
            pos_next     = 1'b0;
            neg_next     = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remote_min_reg  <= REMOTE_RUN_RESET;
            lowbatt_min_reg <= '0;
            test_min_reg    <= '0;
            batt_limit_reg  <= BATT_LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_REMOTE_RUN:  remote_min_reg  <= cfg_data;
                CFG_LOWBATT_RUN: lowbatt_min_reg <= cfg_data;
                CFG_TEST_RUN:    test_min_reg    <= cfg_data;
                CFG_BATT_LIMIT:  batt_limit_reg  <= cfg_data[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            contact_reg   <= 1'b0;
            running_reg   <= 1'b0;
            alarm_reg     <= 1'b0;
            pos_reg       <= 1'b0;
            neg_reg       <= 1'b0;
            phase_reg     <= '0;
            tleft_reg     <= '0;
            armed_reg     <= 1'b0;
            is_test_reg   <= 1'b0;
            holdoff_reg   <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (do_step) begin
                contact_reg <= contact_next;
                running_reg <= running_next;
                alarm_reg   <= alarm_next;
                pos_reg     <= pos_next;
                neg_reg     <= neg_next;
                phase_reg   <= phase_next;
                tleft_reg   <= tleft_next;
                armed_reg   <= armed_next;
                is_test_reg <= is_test_next;
                holdoff_reg <= holdoff_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_op_reg     <= s_opcode;
            in_manual_reg <= s_manual_mode;
            in_sense_reg  <= s_run_sense;
            in_batt_reg   <= s_battery_level;
        end
        if (do_step) begin
            res_relay_reg   <= contact_next;
            res_pos_reg     <= pos_next;
            res_neg_reg     <= neg_next;
            res_running_reg <= running_next;
            res_alarm_reg   <= alarm_next;
            res_notice_reg  <= notice_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_start_relay  = res_relay_reg;
    assign m_out_positive = res_pos_reg;
    assign m_out_negative = res_neg_reg;
    assign m_is_running   = res_running_reg;
    assign m_fail_alarm   = res_alarm_reg;
    assign m_notice       = res_notice_reg;

`ifndef SYNTHESIS
    // outputs and run flag only live while the contact is on
    a_contact_off_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        !contact_reg |-> (!pos_reg && !neg_reg && !running_reg && phase_reg == '0))
        else $error("state active with contact off");

    // positive lead is only connected together with the negative lead
    a_pos_needs_neg: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg |-> neg_reg)
        else $error("positive output without negative output");

    // run loss counter never reaches the failure count while running
    a_run_loss_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        running_reg |-> (phase_reg < PC_W'(RUN_LOSS_TICKS)))
        else $error("run loss counter out of range");

    // a stepped transaction always produces a result
    a_step_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        do_step |=> m_valid)
        else $error("result missing after state update");

    // state moves only when a transaction is processed
    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !do_step |=> ($stable(contact_reg) && $stable(holdoff_reg) && $stable(tleft_reg)))
        else $error("state changed without a transaction");
`endif

endmodule

// ===== tb/sv/generator_start_supervisor_tb.sv =====
`timescale 1ns / 100ps

module generator_start_supervisor_tb;
    import gss_pkg::*;

    localparam int TPS = TICKS_PER_SECOND_DEF;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_COMMANDS = 80;

    typedef struct packed {
        logic                relay;
        logic                pos;
        logic                neg;
        logic                running;
        logic                alarm;
        logic [NOTICE_W-1:0] notice;
    } gen_outputs_t;

    logic                 aclk;
    logic                 aresetn = 1'b0;

    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [OP_W-1:0]      s_opcode = OP_TICK;
    logic                 s_manual_mode = 1'b0;
    logic                 s_run_sense = 1'b0;
    logic [BATT_W-1:0]    s_battery_level = '0;

    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_start_relay;
    logic                 m_out_positive;
    logic                 m_out_negative;
    logic                 m_is_running;
    logic                 m_fail_alarm;
    logic [NOTICE_W-1:0]  m_notice;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_REMOTE_RUN;
    logic [MIN_W-1:0]     cfg_data = '0;

    generator_start_supervisor u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_manual_mode   (s_manual_mode),
        .s_run_sense     (s_run_sense),
        .s_battery_level (s_battery_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_start_relay   (m_start_relay),
        .m_out_positive  (m_out_positive),
        .m_out_negative  (m_out_negative),
        .m_is_running    (m_is_running),
        .m_fail_alarm    (m_fail_alarm),
        .m_notice        (m_notice),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // supervisor state as the block should hold it
    bit                 relay_on, engine_running, alarm_set, pos_on, neg_on;
    bit                 run_timer_armed, run_timer_test;
    int                 phase_ticks, run_ticks_left, batt_holdoff;
    logic [MIN_W-1:0]   remote_minutes, lowbatt_minutes, test_minutes;
    logic [LIMIT_W-1:0] batt_limit;

    gen_outputs_t pending_outputs[$];

    int errors, results_checked, commands_sent, register_writes;
    int starts_confirmed, start_failures, run_losses, timer_expiries, lowbatt_starts;
    int src_gap_max = 12, sink_stall_max = 12;
    int pending_gap;
    bit in_hold;

    logic [OP_W-1:0] start_ops[4] = '{OP_MANUAL_ON, OP_REMOTE_ON, OP_BUS_ON, OP_SCHED_ON};
    logic [OP_W-1:0] stop_ops[4] = '{OP_MANUAL_OFF, OP_REMOTE_OFF, OP_BUS_OFF, OP_SCHED_OFF};

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("generator_start_supervisor_tb: done, errors");
        $finish;
    end

    function automatic void arm_run_timer(logic [MIN_W-1:0] minutes, bit is_test);
        int t;
        t = ((minutes > RUN_MINUTES_MAX) ? int'(RUN_MINUTES_MAX) : int'(minutes)) * 60 * TPS;
        run_ticks_left = (t > int'(TIMEOUT_MAX)) ? int'(TIMEOUT_MAX) : t;
        run_timer_armed = 1'b1;
        run_timer_test = is_test;
    endfunction

    function automatic logic [NOTICE_W-1:0] apply_command(logic [OP_W-1:0] op, bit manual);
        logic [NOTICE_W-1:0] notice;
        notice = NOTICE_NONE;
        case (op)
            OP_MANUAL_ON: relay_on = 1'b1;
            OP_MANUAL_OFF: begin
                relay_on = 1'b0;
                alarm_set = 1'b0;
            end
            OP_REMOTE_ON: begin
                if (manual) begin
                    notice = NOTICE_IGNORED;
                end else begin
                    if (!relay_on) begin
                        arm_run_timer(remote_minutes, 1'b0);
                        relay_on = 1'b1;
                        alarm_set = 1'b0;
                    end
                    notice = (remote_minutes >= RUN_MINUTES_MAX) ? NOTICE_AT_LIMIT
                                                                 : NOTICE_STARTED;
                end
            end
            OP_REMOTE_OFF: begin
                if (manual) begin
                    notice = NOTICE_IGNORED;
                end else begin
                    relay_on = 1'b0;
                    notice = NOTICE_STOPPED;
                end
            end
            OP_BUS_ON: begin
                if (!manual && !relay_on) begin
                    arm_run_timer(remote_minutes, 1'b0);
                    relay_on = 1'b1;
                    alarm_set = 1'b0;
                end
            end
            OP_BUS_OFF: begin
                if (!manual) relay_on = 1'b0;
            end
            OP_SCHED_ON: begin
                if (!manual && !relay_on) begin
                    relay_on = 1'b1;
                    arm_run_timer(test_minutes, 1'b1);
                end
            end
            OP_SCHED_OFF: relay_on = 1'b0;
            default: ;
        endcase
        return notice;
    endfunction

    function automatic void trip_alarm();
        alarm_set = 1'b1;
        engine_running = 1'b0;
        relay_on = 1'b0;
        pos_on = 1'b0;
        neg_on = 1'b0;
        phase_ticks = 0;
        run_timer_armed = 1'b0;
    endfunction

    function automatic void step_start_sequence(bit sense);
        if (!engine_running) begin
            if (phase_ticks == 10 * TPS) begin
                neg_on = 1'b1;
                pos_on = 1'b0;
                phase_ticks++;
            end else if (phase_ticks == 30 * TPS) begin
                start_failures++;
                trip_alarm();
            end else if (phase_ticks > 20 * TPS) begin
                if (sense) begin
                    engine_running = 1'b1;
                    phase_ticks = 0;
                    alarm_set = 1'b0;
                    pos_on = 1'b1;
                    neg_on = 1'b1;
                    starts_confirmed++;
                end else begin
                    phase_ticks++;
                end
            end else begin
                phase_ticks++;
            end
        end else if (sense) begin
            phase_ticks = 0;
        end else begin
            phase_ticks++;
            if (phase_ticks == RUN_LOSS_TICKS) begin
                run_losses++;
                trip_alarm();
            end
        end
    endfunction

    function automatic gen_outputs_t next_generator_outputs(logic [OP_W-1:0] op, bit manual,
                                                            bit sense, logic [BATT_W-1:0] batt);
        gen_outputs_t r;
        logic [NOTICE_W-1:0] notice;
        int lim, h;
        notice = NOTICE_NONE;
        if (op != OP_TICK) begin
            notice = apply_command(op, manual);
        end else begin
            if (run_timer_armed) begin
                if (run_ticks_left > 0) run_ticks_left--;
                if (run_ticks_left == 0) begin
                    run_timer_armed = 1'b0;
                    timer_expiries++;
                    notice = apply_command(run_timer_test ? OP_SCHED_OFF : OP_REMOTE_OFF, manual);
                end
            end
            if (relay_on) begin
                step_start_sequence(sense);
            end else begin
                engine_running = 1'b0;
                phase_ticks = 0;
            end
            if (lowbatt_minutes != 0 && !relay_on) begin
                lim = int'(batt_limit);
                if (lim < int'(BATT_LIMIT_MIN)) lim = int'(BATT_LIMIT_MIN);
                if (lim > int'(BATT_LIMIT_MAX)) lim = int'(BATT_LIMIT_MAX);
                if (int'(batt) < lim && batt != 0 && batt_holdoff == 0) begin
                    h = int'(lowbatt_minutes) * TPS;
                    batt_holdoff = (h > int'(HOLDOFF_MAX)) ? int'(HOLDOFF_MAX) : h;
                    if (!manual && !alarm_set) begin
                        relay_on = 1'b1;
                        arm_run_timer(lowbatt_minutes, 1'b0);
                        lowbatt_starts++;
                    end
                end else if (batt_holdoff > 0) begin
                    batt_holdoff--;
                end
            end
        end
        if (!relay_on) begin
            engine_running = 1'b0;
            phase_ticks = 0;
            pos_on = 1'b0;
            neg_on = 1'b0;
        end
        r.relay = relay_on;
        r.pos = pos_on;
        r.neg = neg_on;
        r.running = engine_running;
        r.alarm = alarm_set;
        r.notice = notice;
        return r;
    endfunction

    function automatic void check_field(string fname, int want, int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        gen_outputs_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_outputs.size() == 0) begin
                $display("%0t: result transaction with nothing expected, notice %0d",
                         $time, m_notice);
                errors++;
            end else begin
                want = pending_outputs.pop_front();
                check_field("start_relay", want.relay, m_start_relay);
                check_field("out_positive", want.pos, m_out_positive);
                check_field("out_negative", want.neg, m_out_negative);
                check_field("is_running", want.running, m_is_running);
                check_field("fail_alarm", want.alarm, m_fail_alarm);
                check_field("notice", want.notice, m_notice);
                results_checked++;
            end
        end
    end

    // result side back-pressure
    initial begin
        int stall;
        forever begin
            stall = $urandom_range(0, sink_stall_max);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!(m_valid && aresetn)) @(posedge aclk);
        end
    end

    task automatic send_item(logic [OP_W-1:0] op, bit manual, bit sense,
                             logic [BATT_W-1:0] batt);
        if (pending_gap > 0) repeat (pending_gap) @(posedge aclk);
        s_valid <= 1'b1;
        s_opcode <= op;
        s_manual_mode <= manual;
        s_run_sense <= sense;
        s_battery_level <= batt;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_outputs.push_back(next_generator_outputs(op, manual, sense, batt));
        if (op <= OP_SCHED_OFF) commands_sent++;
        pending_gap = $urandom_range(0, src_gap_max);
        if (pending_gap > 0) s_valid <= 1'b0;
        in_hold = (pending_gap == 0);
    endtask

    task automatic release_input();
        if (in_hold) begin
            s_valid <= 1'b0;
            in_hold = 1'b0;
        end
    endtask

    task automatic wait_idle();
        release_input();
        while (pending_outputs.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [MIN_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_REMOTE_RUN:  remote_minutes = value;
            CFG_LOWBATT_RUN: lowbatt_minutes = value;
            CFG_TEST_RUN:    test_minutes = value;
            CFG_BATT_LIMIT:  batt_limit = value[LIMIT_W-1:0];
            default: ;
        endcase
        register_writes++;
    endtask

    task automatic write_all_registers(logic [MIN_W-1:0] remote, logic [MIN_W-1:0] lowbatt,
                                       logic [MIN_W-1:0] test_run, logic [MIN_W-1:0] limit);
        write_register(CFG_REMOTE_RUN, remote);
        write_register(CFG_LOWBATT_RUN, lowbatt);
        write_register(CFG_TEST_RUN, test_run);
        write_register(CFG_BATT_LIMIT, limit);
    endtask

    function automatic logic [BATT_W-1:0] pick_battery();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return BATT_W'($urandom_range(1, 9));
            2: return BATT_W'($urandom_range(10, 31));
            3: return '1;
            default: return BATT_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic test_every_command();
        send_item(OP_MANUAL_ON, 1'b1, 1'b0, 8'd255);
        send_item(OP_TICK, 1'b1, 1'b1, 8'd0);
        send_item(OP_MANUAL_OFF, 1'b1, 1'b0, 8'd255);
        send_item(OP_REMOTE_ON, 1'b1, 1'b0, 8'd1);
        send_item(OP_REMOTE_ON, 1'b0, 1'b1, 8'd128);
        // already on: timer kept, notice still given
        send_item(OP_REMOTE_ON, 1'b0, 1'b0, 8'd127);
        send_item(OP_REMOTE_OFF, 1'b1, 1'b1, 8'd0);
        send_item(OP_REMOTE_OFF, 1'b0, 1'b0, 8'd255);
        send_item(OP_BUS_ON, 1'b0, 1'b1, 8'd85);
        send_item(OP_BUS_OFF, 1'b1, 1'b0, 8'd170);
        send_item(OP_BUS_OFF, 1'b0, 1'b0, 8'd0);
        send_item(OP_SCHED_ON, 1'b1, 1'b0, 8'd255);
        send_item(OP_SCHED_ON, 1'b0, 1'b1, 8'd255);
        send_item(OP_SCHED_OFF, 1'b1, 1'b0, 8'd0);
        // unused opcodes leave the state alone
        send_item(OP_SCHED_OFF + 4'd1, 1'b0, 1'b1, 8'd255);
        send_item(4'd12, 1'b1, 1'b0, 8'd0);
        send_item(4'd15, 1'b0, 1'b1, 8'd9);
    endtask

    task automatic test_zero_timeout();
        write_register(CFG_REMOTE_RUN, '0);
        write_register(CFG_TEST_RUN, '0);
        send_item(OP_REMOTE_ON, 1'b0, 1'b0, 8'd200);
        send_item(OP_TICK, 1'b0, 1'b0, 8'd200);
        // expiry as remote-off while in manual mode is refused
        send_item(OP_REMOTE_ON, 1'b0, 1'b0, 8'd200);
        send_item(OP_TICK, 1'b1, 1'b0, 8'd200);
        send_item(OP_MANUAL_OFF, 1'b1, 1'b0, 8'd200);
        send_item(OP_SCHED_ON, 1'b0, 1'b0, 8'd200);
        send_item(OP_TICK, 1'b1, 1'b1, 8'd200);
    endtask

    task automatic test_low_battery_start();
        write_register(CFG_LOWBATT_RUN, 10'd1);
        write_register(CFG_BATT_LIMIT, '1);
        send_item(OP_TICK, 1'b0, 1'b0, 8'd29);
        send_item(OP_REMOTE_OFF, 1'b0, 1'b0, 8'd29);
        send_item(OP_TICK, 1'b0, 1'b0, 8'd29);
        send_item(OP_TICK, 1'b1, 1'b0, 8'd5);
        // hold-off reloads even though manual mode refuses the start
        send_item(OP_TICK, 1'b1, 1'b0, 8'd5);
        send_item(OP_TICK, 1'b0, 1'b0, 8'd0);
    endtask

    task automatic drive_start_and_run();
        logic [OP_W-1:0]   on_op;
        logic [BATT_W-1:0] batt;
        bit manual, sense;
        int sense_at, n_ticks, dropout;
        on_op = start_ops[$urandom_range(0, 3)];
        manual = (on_op == OP_MANUAL_ON);
        if ($urandom_range(0, 9) == 0) manual = !manual;
        batt = ($urandom_range(0, 3) == 0) ? pick_battery() : 8'($urandom_range(32, 255));
        send_item(on_op, manual, 1'b0, batt);
        sense_at = $urandom_range(0, 70);
        n_ticks = $urandom_range(20, 130);
        dropout = 0;
        for (int i = 0; i < n_ticks; i++) begin
            if (dropout > 0) begin
                dropout--;
            end else if (i > sense_at && $urandom_range(0, 24) == 0) begin
                dropout = $urandom_range(1, 12);
            end
            sense = (i >= sense_at) && (dropout == 0);
            if ($urandom_range(0, 19) == 0) manual = !manual;
            if ($urandom_range(0, 9) == 0) batt = pick_battery();
            send_item(OP_TICK, manual, sense, batt);
        end
        if ($urandom_range(0, 2) != 0)
            send_item(stop_ops[$urandom_range(0, 3)], manual, sense, batt);
    endtask

    task automatic drive_idle_ticks();
        int n;
        bit manual;
        n = $urandom_range(5, 20);
        manual = $urandom_range(0, 3) == 0;
        for (int i = 0; i < n; i++)
            send_item(OP_TICK, manual, 1'($urandom_range(0, 1)), pick_battery());
    endtask

    task automatic drive_noise();
        int n;
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            send_item(OP_W'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), BATT_W'($urandom_range(0, 255)));
    endtask

    task automatic test_random_operation();
        int target;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: write_all_registers(10'd1, 10'd1, 10'd1, 10'd30);
                1: write_all_registers(RUN_MINUTES_MAX, '0, '0, 10'd10);
                2: write_all_registers('1, '1, '1, '0);
                3: write_all_registers(10'd2, 10'd2, RUN_MINUTES_MAX, 10'd20);
                default: write_all_registers(MIN_W'($urandom_range(0, 3)),
                                             MIN_W'($urandom_range(0, 3)),
                                             MIN_W'($urandom_range(0, 3)),
                                             MIN_W'($urandom_range(0, 31)));
            endcase
            target = commands_sent + PHASE_COMMANDS;
            while (commands_sent < target) begin
                src_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
                sink_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: drive_start_and_run();
                    6, 7: drive_idle_ticks();
                    default: drive_noise();
                endcase
            end
        end
        src_gap_max = 12;
        sink_stall_max = 12;
    endtask

    initial begin
        remote_minutes = REMOTE_RUN_RESET;
        lowbatt_minutes = '0;
        test_minutes = '0;
        batt_limit = BATT_LIMIT_RESET;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_every_command();
        test_zero_timeout();
        test_low_battery_start();
        test_random_operation();

        release_input();
        for (int w = 0; w < 10000 && pending_outputs.size() != 0; w++) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (pending_outputs.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, pending_outputs.size());
            errors++;
        end

        $display("covered %0d commands and ticks, %0d results checked, %0d register writes",
                 commands_sent, results_checked, register_writes);
        $display("starts %0d, start failures %0d, run losses %0d, timer expiries %0d, %s %0d",
                 starts_confirmed, start_failures, run_losses, timer_expiries,
                 "low battery starts", lowbatt_starts);
        if (errors == 0) begin
            $display("generator_start_supervisor_tb: done, clean");
        end else begin
            $display("generator_start_supervisor_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/gss_pkg.sv
hdl/generator_start_supervisor.sv
tb/sv/generator_start_supervisor_tb.sv
